### rtl/pnc_pkg.sv
// Shared definitions for the perfect number counter: widths, sequencer states
// and the control structs passed between its modules. No dependencies.
package pnc_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int SUM_BITS       = 24;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_FINISH
  } pnc_state_e;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } pnc_div_status_t;

  typedef struct packed {
    logic valid;
    logic is_perfect;
    logic set_done;
  } pnc_res_ctl_t;

endpackage

### rtl/pnc_if.sv
// Valid/ready channel interfaces for the perfect number counter items.
// Depends on pnc_pkg for the default widths.
interface pnc_in_if import pnc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last_in_set;

  modport source (output valid, output value, output last_in_set, input ready);
  modport sink   (input valid, input value, input last_in_set, output ready);
endinterface

interface pnc_out_if import pnc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  is_perfect;
  logic [SUM_BITS-1:0]   divisor_sum;
  logic [COUNT_BITS-1:0] perfect_count;
  logic                  set_done;

  modport source (output valid, output is_perfect, output divisor_sum,
                  output perfect_count, output set_done, input ready);
  modport sink   (input valid, input is_perfect, input divisor_sum,
                  input perfect_count, input set_done, output ready);
endinterface

### rtl/perfect_number_counter_core.sv
// Top level of the perfect number counter: channel handling, output register,
// sequencer and remainder unit. Depends on pnc_pkg, pnc_if, pnc_ctrl, pnc_divider.
//
// Usage: each input item carries a signed value and a last_in_set flag; each
// produces exactly one output item with the perfect flag, the sum of proper
// divisors (saturating at 24 bits), the perfect count of the current set
// including this item, and set_done, a copy of last_in_set. The count is
// cleared after the item that closes a set.
// Method: a positive value v above one is tested against every trial divisor
// 1 to v-1; each trial is one pass of the bit-serial remainder unit. Zero, one
// and negative values skip the trials and go straight to the result.
// One item is in work at a time; in_i.ready is high only while idle.
// The finished result sits in an output register, so the next item is taken
// while a result waits; a stalled receiver holds the item steady and only
// blocks the sequencer when a second result is ready.
// Reset clears the sequencer, the divisor sum, the set count and out_o.valid.
module perfect_number_counter_core import pnc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pnc_in_if.sink    in_i,
  pnc_out_if.source out_o
);

  pnc_res_ctl_t          res;
  pnc_div_status_t       div_status;
  logic [SUM_BITS-1:0]   res_sum;
  logic [COUNT_BITS-1:0] res_count;
  logic                  res_take;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_divisor;
  logic                  out_valid_q, out_valid_d;
  logic                  is_perfect_q;
  logic [SUM_BITS-1:0]   sum_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  set_done_q;

  assign res_take = res.valid && (!out_valid_q || out_o.ready);

  pnc_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .value_i        (in_i.value),
    .last_i         (in_i.last_in_set),
    .res_take_i     (res_take),
    .res_o          (res),
    .sum_o          (res_sum),
    .count_o        (res_count),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_status_i   (div_status)
  );

  pnc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      is_perfect_q <= res.is_perfect;
      sum_q        <= res_sum;
      count_q      <= res_count;
      set_done_q   <= res.set_done;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.is_perfect    = is_perfect_q;
  assign out_o.divisor_sum   = sum_q;
  assign out_o.perfect_count = count_q;
  assign out_o.set_done      = set_done_q;

endmodule

### rtl/pnc_divider.sv
// Restoring remainder unit: one quotient bit per cycle, done as a one-cycle
// pulse once the last bit is in. Depends on pnc_pkg.
module pnc_divider import pnc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output pnc_div_status_t       status_o
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] dvd_q, dvd_d;
  logic [VALUE_BITS-1:0] dvs_q, dvs_d;
  logic [VALUE_BITS-1:0] rem_sh;
  logic [VALUE_BITS-1:0] rem_nx;

  assign rem_sh = {rem_q[VALUE_BITS-2:0], dvd_q[VALUE_BITS-1]};
  assign rem_nx = (rem_sh >= dvs_q) ? (rem_sh - dvs_q) : rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = rem_nx;
      dvd_d = {dvd_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);

endmodule

### rtl/pnc_ctrl.sv
// Sequencer for the trial division: steps the trial divisor, accumulates the
// saturating divisor sum and keeps the per-set count. Depends on pnc_pkg.
module pnc_ctrl import pnc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  input  logic                  res_take_i,
  output pnc_res_ctl_t          res_o,
  output logic [SUM_BITS-1:0]   sum_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  div_start_o,
  output logic [VALUE_BITS-1:0] div_dividend_o,
  output logic [VALUE_BITS-1:0] div_divisor_o,
  input  pnc_div_status_t       div_status_i
);

  localparam int ACC_W = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;

  pnc_state_e            state_q, state_d;
  logic [VALUE_BITS-1:0] d_q, d_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [VALUE_BITS-1:0] v_q;
  logic                  pos_q;
  logic                  last_q;
  logic                  load_in;
  logic                  positive;
  logic [ACC_W-1:0]      sum_add;
  logic [SUM_BITS-1:0]   sum_sat;
  logic [VALUE_BITS-1:0] d_inc;
  logic                  perfect;
  logic [COUNT_BITS-1:0] count_inc;

  assign positive  = !value_i[VALUE_BITS-1] && (value_i != '0);
  assign sum_add   = ACC_W'(sum_q) + ACC_W'(d_q);
  assign sum_sat   = (sum_add > ACC_W'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_BITS-1:0];
  assign d_inc     = d_q + VALUE_BITS'(1);
  assign perfect   = pos_q && (ACC_W'(sum_q) == ACC_W'(v_q));
  assign count_inc = (perfect && (count_q != '1)) ? (count_q + COUNT_BITS'(1)) : count_q;

  always_comb begin
    state_d          = state_q;
    d_d              = d_q;
    sum_d            = sum_q;
    count_d          = count_q;
    in_ready_o       = 1'b0;
    load_in          = 1'b0;
    div_start_o      = 1'b0;
    div_dividend_o   = v_q;
    div_divisor_o    = d_q;
    res_o.valid      = 1'b0;
    res_o.is_perfect = perfect;
    res_o.set_done   = last_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_in = 1'b1;
          d_d     = VALUE_BITS'(1);
          sum_d   = '0;
          if (positive && (value_i != VALUE_BITS'(1))) begin
            div_start_o    = 1'b1;
            div_dividend_o = value_i;
            div_divisor_o  = VALUE_BITS'(1);
            state_d        = ST_WAIT;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WAIT: begin
        if (div_status_i.done) begin
          if (div_status_i.rem_zero) begin
            sum_d = sum_sat;
          end
          if (d_inc != v_q) begin
            d_d           = d_inc;
            div_start_o   = 1'b1;
            div_divisor_o = d_inc;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        res_o.valid = 1'b1;
        if (res_take_i) begin
          count_d = last_q ? '0 : count_inc;
          d_d     = VALUE_BITS'(1);
          sum_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      d_q     <= VALUE_BITS'(1);
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      d_q     <= d_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      v_q    <= value_i;
      pos_q  <= positive;
      last_q <= last_i;
    end
  end

  assign sum_o            = sum_q;
  assign count_o          = count_inc;

endmodule

### rtl/pnc_checker.sv
// Port-level checks for the perfect number counter, bound to the top level.
// Depends on pnc_pkg and perfect_number_counter_core.
module pnc_checker import pnc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  is_perfect_i,
  input logic [SUM_BITS-1:0]   divisor_sum_i,
  input logic [COUNT_BITS-1:0] perfect_count_i,
  input logic                  set_done_i
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output item withdrawn while stalled.");

  a_out_item_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(is_perfect_i) && $stable(divisor_sum_i)
      && $stable(perfect_count_i) && $stable(set_done_i))
    else $error("Output item changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Input taken again while an item is in work.");

  a_perfect_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_perfect_i |-> perfect_count_i != '0)
    else $error("Perfect item reported with a zero count.");

endmodule

bind perfect_number_counter_core pnc_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_pnc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .is_perfect_i    (out_o.is_perfect),
  .divisor_sum_i   (out_o.divisor_sum),
  .perfect_count_i (out_o.perfect_count),
  .set_done_i      (out_o.set_done)
);

### tb/tb_top.sv
// Self-checking testbench for perfect_number_counter_core: directed rows, then random
// items through valid/ready channels with random gaps and stalls, checked against a predictor.
// Depends on pnc_pkg, the channel interfaces in pnc_if and the core itself.
module tb_top;
  import pnc_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int CB = COUNT_BITS_DEF;
  localparam logic [CB-1:0] TALLY_MAX = '1;
  localparam int IDLE_LIMIT = 2_000_000;
  localparam int N_RANDOM = 100;
  localparam int N_ROWS = 16;

  typedef struct packed {
    logic          is_perfect;
    logic [SUM_BITS-1:0] divisor_sum;
    logic [CB-1:0] perfect_count;
    logic          set_done;
  } divisor_result_t;

  typedef struct packed {
    logic signed [VB-1:0] value;
    logic                 last;
    logic                 typed;
    divisor_result_t      res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pnc_in_if  #(.VALUE_BITS(VB)) in_ch ();
  pnc_out_if #(.COUNT_BITS(CB)) out_ch ();

  perfect_number_counter_core #(
    .VALUE_BITS(VB),
    .COUNT_BITS(CB)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  divisor_result_t pending_results[$];
  divisor_result_t oldest;
  logic [CB-1:0]   perfect_tally;
  int              n_err;
  int              burst_left;
  int              idle_cycles;
  logic [15:0]     stall_pat;
  int              stall_idx;
  stim_row_t       directed_rows[N_ROWS];

  always #5 clk_i = ~clk_i;

  function automatic logic [SUM_BITS-1:0] proper_divisor_total(logic signed [VB-1:0] v);
    longint acc;
    int     n;
    acc = 0;
    n = int'(v);
    for (int d = 1; d < n; d++) begin
      if (n % d == 0) begin
        acc += longint'(d);
        if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
      end
    end
    return acc[SUM_BITS-1:0];
  endfunction

  function automatic divisor_result_t predict_result(logic signed [VB-1:0] v, logic last);
    divisor_result_t r;
    r = '0;
    if (v > 0) begin
      r.divisor_sum = proper_divisor_total(v);
      r.is_perfect = (r.divisor_sum == SUM_BITS'(v));
    end
    if (r.is_perfect && perfect_tally != TALLY_MAX) perfect_tally++;
    r.perfect_count = perfect_tally;
    r.set_done = last;
    if (last) perfect_tally = '0;
    return r;
  endfunction

  function automatic logic signed [VB-1:0] random_value();
    logic [VB-1:0] r;
    int            sel;
    sel = $urandom_range(0, 99);
    r = VB'($urandom);
    if (sel < 30) begin
      r[VB-1] = 1'b1;
    end else if (sel < 35) begin
      r = '0;
    end else if (sel < 45) begin
      case ($urandom_range(0, 3))
        0: r = VB'(1);
        1: r = VB'(6);
        2: r = VB'(28);
        default: r = VB'(496);
      endcase
    end else if (sel < 97) begin
      r = VB'($urandom_range(2, 300));
    end else begin
      r = VB'($urandom_range(301, 2000));
    end
    return r;
  endfunction

  task automatic send_item(input logic signed [VB-1:0] v, input logic last,
                           input logic typed, input divisor_result_t typed_res);
    int gap;
    divisor_result_t pred;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      in_ch.value <= VB'($urandom);
      in_ch.last_in_set <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last_in_set <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = predict_result(v, last);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_err++;
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_idx == 63) begin
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
    end
    stall_idx <= (stall_idx + 1) % 64;
    out_ch.ready <= ~stall_pat[stall_idx[3:0]];
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, actual %0h %0h %0h %0h", $time, out_ch.is_perfect,
                 out_ch.divisor_sum, out_ch.perfect_count, out_ch.set_done);
        n_err++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("is_perfect", 64'(oldest.is_perfect), 64'(out_ch.is_perfect));
        check_field("divisor_sum", 64'(oldest.divisor_sum), 64'(out_ch.divisor_sum));
        check_field("perfect_count", 64'(oldest.perfect_count), 64'(out_ch.perfect_count));
        check_field("set_done", 64'(oldest.set_done), 64'(out_ch.set_done));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last_in_set = 1'b0;
    out_ch.ready = 1'b0;
    stall_pat = 16'h0000;
    stall_idx = 0;
    idle_cycles = 0;
    perfect_tally = '0;
    n_err = 0;
    burst_left = 0;
    directed_rows = '{
      '{16'sd0,      1'b0, 1'b1, '{1'b0, 24'd0,    16'd0, 1'b0}},
      '{-16'sd1,     1'b0, 1'b1, '{1'b0, 24'd0,    16'd0, 1'b0}},
      '{16'sh8000,   1'b0, 1'b1, '{1'b0, 24'd0,    16'd0, 1'b0}},
      '{16'sd1,      1'b0, 1'b1, '{1'b0, 24'd0,    16'd0, 1'b0}},
      '{16'sd6,      1'b0, 1'b1, '{1'b1, 24'd6,    16'd1, 1'b0}},
      '{16'sd28,     1'b0, 1'b1, '{1'b1, 24'd28,   16'd2, 1'b0}},
      '{16'sd0,      1'b1, 1'b1, '{1'b0, 24'd0,    16'd2, 1'b1}},
      '{16'sd496,    1'b0, 1'b1, '{1'b1, 24'd496,  16'd1, 1'b0}},
      '{16'sd2,      1'b0, 1'b0, '0},
      '{16'sd12,     1'b0, 1'b0, '0},
      '{16'sd32767,  1'b0, 1'b0, '0},
      '{-16'sd16384, 1'b0, 1'b1, '{1'b0, 24'd0,    16'd1, 1'b0}},
      '{16'sd8128,   1'b1, 1'b1, '{1'b1, 24'd8128, 16'd2, 1'b1}},
      '{16'sd16,     1'b1, 1'b0, '0},
      '{16'sd6,      1'b1, 1'b1, '{1'b1, 24'd6,    16'd1, 1'b1}},
      '{-16'sd2,     1'b1, 1'b1, '{1'b0, 24'd0,    16'd0, 1'b1}}
    };
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      send_item(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].res);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      send_item(random_value(), ($urandom_range(0, 5) == 0), 1'b0, '0);
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
